### design/apf_pkg.sv
// apf_pkg: shared types, codes and constants of the animation playback fader
// depends on nothing; imported by apf_alu and animation_playback_fader_top
`timescale 1ns / 1ps

package apf_pkg;

    localparam int unsigned COS_TABLE_DEPTH_DEF = 256;
    localparam int unsigned TIME_FRAC_BITS_DEF  = 16;

    localparam int ALU_W      = 64;
    localparam int CNT_W      = 7;
    localparam int IN_DATA_W  = 96;
    localparam int OUT_DATA_W = 72;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [15:0] ONE_Q15 = 16'd32768;

    // iteration counts of the shared unit
    localparam logic [CNT_W-1:0] IT_MUL16 = 7'd16;
    localparam logic [CNT_W-1:0] IT_MUL32 = 7'd32;
    localparam logic [CNT_W-1:0] IT_DIV   = 7'd64;

    typedef enum logic [1:0] {
        PH_IDLE     = 2'd0,
        PH_FADE_IN  = 2'd1,
        PH_PLAY     = 2'd2,
        PH_FADE_OUT = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        FN_TICK  = 2'd0,
        FN_PLAY  = 2'd1,
        FN_STOP  = 2'd2,
        FN_RESET = 2'd3
    } func_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION = 3'd0,
        CFG_TPS      = 3'd1,
        CFG_SPEED    = 3'd2,
        CFG_OFFSET   = 3'd3,
        CFG_WEIGHT   = 3'd4,
        CFG_LOOPS    = 3'd5,
        CFG_HOLD     = 3'd6
    } cfg_idx_t;

    typedef enum logic {
        ALU_MUL = 1'b0,
        ALU_DIV = 1'b1
    } alu_op_t;

    typedef struct packed {
        logic    start;
        alu_op_t op;
    } alu_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } alu_stat_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WAIT,
        S_P_POS,
        S_P_FIN,
        S_T_STEP,
        S_T_SUM,
        S_T_WRAP,
        S_T_FADE,
        S_T_LIM,
        S_T_IDX,
        S_T_LVL,
        S_T_EARLY,
        S_T_DURS,
        S_T_MAXP,
        S_OUT
    } state_t;

endpackage

### design/apf_alu.sv
// apf_alu: shared bit-serial unit, shift-add multiply and restoring divide
// one bit per cycle on 64-bit operands; depends on apf_pkg
`timescale 1ns / 1ps

module apf_alu
    import apf_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  alu_cmd_t         cmd,
    input  logic [ALU_W-1:0] opa,
    input  logic [ALU_W-1:0] opb,
    input  logic [CNT_W-1:0] iters,
    output alu_stat_t        stat,
    output logic [ALU_W-1:0] acc,
    output logic [ALU_W-1:0] quo
);

    logic [ALU_W-1:0] acc_reg, acc_next;
    logic [ALU_W-1:0] x_reg, x_next;
    logic [ALU_W-1:0] y_reg, y_next;
    alu_op_t          op_reg, op_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             busy_reg, busy_next;
    logic             done_reg, done_next;

    logic [ALU_W:0]   shifted;
    logic [ALU_W+1:0] diff;
    logic             ge;

    // partial remainder with the next dividend bit shifted in
    assign shifted = {acc_reg, x_reg[ALU_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, y_reg};
    assign ge      = ~diff[ALU_W+1];

    always_comb
    begin
        acc_next  = acc_reg;
        x_next    = x_reg;
        y_next    = y_reg;
        op_next   = op_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (cmd.start)
        begin
            acc_next  = '0;
            x_next    = opa;
            y_next    = opb;
            op_next   = cmd.op;
            cnt_next  = iters;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (op_reg == ALU_MUL)
            begin
                if (y_reg[0])
                begin
                    acc_next = acc_reg + x_reg;
                end
                x_next = {x_reg[ALU_W-2:0], 1'b0};
                y_next = {1'b0, y_reg[ALU_W-1:1]};
            end
            else
            begin
                acc_next = ge ? diff[ALU_W-1:0] : shifted[ALU_W-1:0];
                x_next   = {x_reg[ALU_W-2:0], ge};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == 7'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            op_reg   <= ALU_MUL;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            op_reg   <= op_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg <= acc_next;
        x_reg   <= x_next;
        y_reg   <= y_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign acc       = acc_reg;
    assign quo       = x_reg;

endmodule

### design/apf_rc_rom.sv
// apf_rc_rom: raised-cosine fade curve table with registered read
// entries computed at elaboration from a fixed-point sine series; no dependencies
`timescale 1ns / 1ps

module apf_rc_rom
#(
    parameter int unsigned COS_TABLE_DEPTH = 256,
    parameter int unsigned AW              = 9
)
(
    input  logic          clk,
    input  logic [AW-1:0] addr,
    output logic [15:0]   rc
);

    localparam longint unsigned PI_Q30  = 64'd3373259426;
    localparam longint unsigned ONE_Q30 = 64'd1073741824;

    logic [15:0] tab [0:COS_TABLE_DEPTH];
    logic [15:0] rc_reg;

    // sin^2 of pi*idx/(2*depth) in Q1.15, sine as Q30 series to the 13th power
    for (genvar i = 0; i <= COS_TABLE_DEPTH; i++)
    begin : g_tab
        localparam longint unsigned T   = (PI_Q30 * 64'(i)) / (64'd2 * 64'(COS_TABLE_DEPTH));
        // each odd term is built from the one before
        localparam longint unsigned P3  = ((((T * T) >> 30) * T) >> 30) / 64'd6;
        localparam longint unsigned P5  = ((((P3 * T) >> 30) * T) >> 30) / 64'd20;
        localparam longint unsigned P7  = ((((P5 * T) >> 30) * T) >> 30) / 64'd42;
        localparam longint unsigned P9  = ((((P7 * T) >> 30) * T) >> 30) / 64'd72;
        localparam longint unsigned P11 = ((((P9 * T) >> 30) * T) >> 30) / 64'd110;
        localparam longint unsigned P13 = ((((P11 * T) >> 30) * T) >> 30) / 64'd156;
        localparam longint          S   = longint'(T) - longint'(P3) + longint'(P5)
                                        - longint'(P7) + longint'(P9) - longint'(P11)
                                        + longint'(P13);
        // sine clamped to [0,1]
        localparam longint unsigned SC  = (S < 0) ? 64'd0 :
                                          ((S > longint'(ONE_Q30)) ? ONE_Q30 : 64'(S));
        localparam longint unsigned Q   = (((SC * SC) >> 30) + 64'd16384) >> 15;
        localparam logic [15:0]     V   = (Q > 64'd32768) ? 16'd32768 : 16'(Q);
        assign tab[i] = V;
    end

    always_ff @(posedge clk)
    begin
        rc_reg <= tab[addr];
    end

    assign rc = rc_reg;

endmodule

### design/animation_playback_fader_top.sv
// animation_playback_fader_top: playback phases, clip time and fade level sequencer
// depends on apf_pkg, apf_alu (shared multiply/divide) and apf_rc_rom (fade curve)
// sequence: stop, reset, play while fading in or playing and an idle tick go from the
//   idle state straight to the output state; play from fade-out passes S_P_FIN first
// throughput: one item at a time, set by the bit-serial unit (1 bit per cycle,
//   up to five divides per tick)
// reset: asynchronous, clears phase and state, loads register defaults
`timescale 1ns / 1ps

module animation_playback_fader_top
    import apf_pkg::*;
#(
    parameter int unsigned COS_TABLE_DEPTH = COS_TABLE_DEPTH_DEF,
    parameter int unsigned TIME_FRAC_BITS  = TIME_FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input item stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // now_time[31:0], delta_time[47:32], fade_in_request[71:48],
    // fade_out_request[95:72]
    input  logic [IN_DATA_W-1:0]  s_tdata,
    // func[1:0]
    input  logic [1:0]            s_tuser,
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // phase_code[1:0], is_active[2], clip_time[34:3], fade_level[50:35],
    // weighted_level[66:51], zero fill [71:67]
    output logic [OUT_DATA_W-1:0] m_tdata,
    // register write channel
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int unsigned AW = $clog2(COS_TABLE_DEPTH + 1);

    // configuration registers
    logic [31:0] clip_duration_reg;
    logic [31:0] ticks_per_second_reg;
    logic [15:0] play_speed_reg;
    logic [31:0] start_offset_reg;
    logic [15:0] blend_weight_reg;
    logic        loops_reg;
    logic        holds_at_end_reg;

    // playback state
    state_t      state_reg, state_next;
    state_t      ret_reg, ret_next;
    phase_t      phase_reg, phase_next;
    logic [31:0] position_reg, position_next;
    logic [15:0] level_reg, level_next;
    logic [15:0] lac_reg, lac_next;
    logic [31:0] change_moment_reg, change_moment_next;
    logic [31:0] play_moment_reg, play_moment_next;
    logic [23:0] fin_len_reg, fin_len_next;
    logic [23:0] fout_len_reg, fout_len_next;

    // captured input transaction
    logic [31:0] now_reg, now_next;
    logic [23:0] fin_req_reg, fin_req_next;

    // output register
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg, m_tdata_next;

    // shared unit
    alu_cmd_t         alu_cmd;
    alu_stat_t        alu_st;
    logic [ALU_W-1:0] alu_a, alu_b, alu_acc, alu_quo;
    logic [CNT_W-1:0] alu_it;

    logic [AW-1:0] rom_addr;
    logic [15:0]   rc;

    // input field split
    func_t       in_func;
    logic [31:0] in_now;
    logic [15:0] in_delta;
    logic [23:0] in_fin;
    logic [23:0] in_fout;

    assign in_func  = func_t'(s_tuser);
    assign in_now   = s_tdata[31:0];
    assign in_delta = s_tdata[47:32];
    assign in_fin   = s_tdata[71:48];
    assign in_fout  = s_tdata[95:72];

    // derived values
    logic [15:0]      speed_div;
    logic [31:0]      tps_div;
    logic [31:0]      prog_cm, prog_pm;
    logic [23:0]      fade_len;
    logic [ALU_W-1:0] step_shift, off_shift;
    logic [31:0]      step32, off32, sum32;
    logic [32:0]      sum33;
    logic [ALU_W-1:0] idx_dividend;
    logic [AW-1:0]    idx_clamped;
    logic [16:0]      lvl_a, lvl_b;
    logic [33:0]      lvl_prod;
    logic [15:0]      bw_sat;
    logic [31:0]      w_prod;
    logic             is_active;

    assign speed_div = (play_speed_reg == 16'd0) ? 16'd1 : play_speed_reg;
    assign tps_div   = (ticks_per_second_reg == 32'd0) ? 32'd1 : ticks_per_second_reg;
    // progress saturates at zero when engine time runs backwards
    assign prog_cm   = (now_reg >= change_moment_reg) ? now_reg - change_moment_reg : 32'd0;
    assign prog_pm   = (now_reg >= play_moment_reg) ? now_reg - play_moment_reg : 32'd0;
    assign fade_len  = (phase_reg == PH_FADE_IN) ? fin_len_reg : fout_len_reg;

    assign step_shift = alu_acc >> (TIME_FRAC_BITS + 8);
    assign step32     = (|step_shift[ALU_W-1:32]) ? 32'hFFFF_FFFF : step_shift[31:0];
    assign sum33      = {1'b0, position_reg} + {1'b0, step32};
    assign sum32      = sum33[32] ? 32'hFFFF_FFFF : sum33[31:0];
    assign off_shift  = alu_acc >> TIME_FRAC_BITS;
    assign off32      = (|off_shift[ALU_W-1:32]) ? 32'hFFFF_FFFF : off_shift[31:0];

    assign idx_dividend = 64'(prog_cm) * 64'(COS_TABLE_DEPTH);
    assign idx_clamped  = (alu_quo > 64'(COS_TABLE_DEPTH)) ? AW'(COS_TABLE_DEPTH)
                                                           : alu_quo[AW-1:0];

    // fade-in rises from the level at the change, fade-out falls toward zero
    always_comb
    begin
        if (phase_reg == PH_FADE_IN)
        begin
            lvl_a = {1'b0, rc};
            lvl_b = {1'b0, ONE_Q15} - {1'b0, lac_reg};
        end
        else
        begin
            lvl_a = {1'b0, ONE_Q15} - {1'b0, rc};
            lvl_b = {1'b0, lac_reg};
        end
    end
    assign lvl_prod = lvl_a * lvl_b;

    assign bw_sat    = (blend_weight_reg > ONE_Q15) ? ONE_Q15 : blend_weight_reg;
    assign w_prod    = bw_sat * level_reg;
    assign is_active = (phase_reg != PH_IDLE);

    apf_alu u_alu
    (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (alu_cmd),
        .opa   (alu_a),
        .opb   (alu_b),
        .iters (alu_it),
        .stat  (alu_st),
        .acc   (alu_acc),
        .quo   (alu_quo)
    );

    apf_rc_rom #(
        .COS_TABLE_DEPTH (COS_TABLE_DEPTH),
        .AW              (AW)
    ) u_rom (
        .clk  (clk),
        .addr (rom_addr),
        .rc   (rc)
    );

    // sequencer: each state consumes the last unit result and may issue the next
    always_comb
    begin
        state_next         = state_reg;
        ret_next           = ret_reg;
        phase_next         = phase_reg;
        position_next      = position_reg;
        level_next         = level_reg;
        lac_next           = lac_reg;
        change_moment_next = change_moment_reg;
        play_moment_next   = play_moment_reg;
        fin_len_next       = fin_len_reg;
        fout_len_next      = fout_len_reg;
        now_next           = now_reg;
        fin_req_next       = fin_req_reg;
        m_tvalid_next      = m_tvalid_reg & ~m_tready;
        m_tdata_next       = m_tdata_reg;
        alu_cmd.start      = 1'b0;
        alu_cmd.op         = ALU_MUL;
        alu_a              = '0;
        alu_b              = '0;
        alu_it             = '0;
        rom_addr           = idx_clamped;

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next      = in_now;
                    fin_req_next  = in_fin;
                    state_next    = S_OUT;
                    case (in_func)
                        FN_TICK:
                        begin
                            if (phase_reg != PH_IDLE)
                            begin
                                // tps * delta first, speed after
                                alu_cmd.start = 1'b1;
                                alu_cmd.op    = ALU_MUL;
                                alu_a         = 64'(ticks_per_second_reg);
                                alu_b         = 64'(in_delta);
                                alu_it        = IT_MUL16;
                                ret_next      = S_T_STEP;
                                state_next    = S_WAIT;
                            end
                        end
                        FN_PLAY:
                        begin
                            fout_len_next = in_fout;
                            if (phase_reg == PH_IDLE)
                            begin
                                alu_cmd.start = 1'b1;
                                alu_cmd.op    = ALU_MUL;
                                alu_a         = 64'(start_offset_reg);
                                alu_b         = 64'(ticks_per_second_reg);
                                alu_it        = IT_MUL32;
                                ret_next      = S_P_POS;
                                state_next    = S_WAIT;
                            end
                            else if (phase_reg == PH_FADE_OUT)
                            begin
                                state_next = S_P_FIN;
                            end
                        end
                        FN_STOP:
                        begin
                            if (phase_reg == PH_FADE_IN || phase_reg == PH_PLAY)
                            begin
                                fout_len_next      = in_fout;
                                change_moment_next = in_now;
                                lac_next           = level_reg;
                                phase_next         = PH_FADE_OUT;
                            end
                        end
                        default:
                        begin
                            position_next = '0;
                            phase_next    = PH_IDLE;
                            level_next    = '0;
                        end
                    endcase
                end
            end
            S_WAIT:
            begin
                if (alu_st.done)
                begin
                    state_next = ret_reg;
                end
            end
            S_P_POS:
            begin
                position_next = off32;
                state_next    = S_P_FIN;
            end
            S_P_FIN:
            begin
                // a clip that does not repeat restarts from zero
                if (!loops_reg)
                begin
                    position_next = '0;
                    level_next    = '0;
                    lac_next      = '0;
                end
                else
                begin
                    lac_next = level_reg;
                end
                fin_len_next       = fin_req_reg;
                play_moment_next   = now_reg;
                change_moment_next = now_reg;
                phase_next         = PH_FADE_IN;
                state_next         = S_OUT;
            end
            S_T_STEP:
            begin
                alu_cmd.start = 1'b1;
                alu_cmd.op    = ALU_MUL;
                alu_a         = alu_acc;
                alu_b         = 64'(play_speed_reg);
                alu_it        = IT_MUL16;
                ret_next      = S_T_SUM;
                state_next    = S_WAIT;
            end
            S_T_SUM:
            begin
                state_next = S_T_FADE;
                if (sum32 > clip_duration_reg)
                begin
                    if (!holds_at_end_reg)
                    begin
                        if (clip_duration_reg == 32'd0)
                        begin
                            position_next = '0;
                        end
                        else
                        begin
                            alu_cmd.start = 1'b1;
                            alu_cmd.op    = ALU_DIV;
                            alu_a         = 64'(sum32);
                            alu_b         = 64'(clip_duration_reg);
                            alu_it        = IT_DIV;
                            ret_next      = S_T_WRAP;
                            state_next    = S_WAIT;
                        end
                    end
                end
                else
                begin
                    position_next = sum32;
                end
            end
            S_T_WRAP:
            begin
                position_next = alu_acc[31:0];
                state_next    = S_T_FADE;
            end
            S_T_FADE:
            begin
                if (phase_reg == PH_FADE_IN || phase_reg == PH_FADE_OUT)
                begin
                    // fade limit = (length << 8) / speed
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_DIV;
                    alu_a         = 64'(fade_len) << 8;
                    alu_b         = 64'(speed_div);
                    alu_it        = IT_DIV;
                    ret_next      = S_T_LIM;
                    state_next    = S_WAIT;
                end
                else
                begin
                    state_next = S_T_EARLY;
                end
            end
            S_T_LIM:
            begin
                if (alu_quo[31:0] == 32'd0 || prog_cm > alu_quo[31:0])
                begin
                    // fade finished
                    change_moment_next = now_reg;
                    if (phase_reg == PH_FADE_IN)
                    begin
                        phase_next = PH_PLAY;
                        level_next = ONE_Q15;
                    end
                    else
                    begin
                        phase_next = PH_IDLE;
                        level_next = '0;
                    end
                    state_next = S_T_EARLY;
                end
                else
                begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_DIV;
                    alu_a         = idx_dividend;
                    alu_b         = 64'(alu_quo[31:0]);
                    alu_it        = IT_DIV;
                    ret_next      = S_T_IDX;
                    state_next    = S_WAIT;
                end
            end
            S_T_IDX:
            begin
                // curve lookup address is on rom_addr in this state
                state_next = S_T_LVL;
            end
            S_T_LVL:
            begin
                if (phase_reg == PH_FADE_IN)
                    level_next = lac_reg + lvl_prod[30:15];
                else
                    level_next = lvl_prod[30:15];
                state_next = S_T_EARLY;
            end
            S_T_EARLY:
            begin
                state_next = S_OUT;
                if (!loops_reg && !holds_at_end_reg &&
                    (phase_reg == PH_FADE_IN || phase_reg == PH_PLAY))
                begin
                    // clip length in seconds
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_DIV;
                    alu_a         = 64'(clip_duration_reg) << TIME_FRAC_BITS;
                    alu_b         = 64'(tps_div);
                    alu_it        = IT_DIV;
                    ret_next      = S_T_DURS;
                    state_next    = S_WAIT;
                end
            end
            S_T_DURS:
            begin
                if (64'(fout_len_reg) > alu_quo)
                begin
                    change_moment_next = now_reg;
                    lac_next           = level_reg;
                    phase_next         = PH_FADE_OUT;
                    state_next         = S_OUT;
                end
                else
                begin
                    alu_cmd.start = 1'b1;
                    alu_cmd.op    = ALU_DIV;
                    alu_a         = (alu_quo - 64'(fout_len_reg)) << 8;
                    alu_b         = 64'(speed_div);
                    alu_it        = IT_DIV;
                    ret_next      = S_T_MAXP;
                    state_next    = S_WAIT;
                end
            end
            S_T_MAXP:
            begin
                // early fade-out so the fade ends with the clip
                if (64'(prog_pm) > alu_quo)
                begin
                    change_moment_next = now_reg;
                    lac_next           = level_reg;
                    phase_next         = PH_FADE_OUT;
                end
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {5'b0, w_prod[30:15], level_reg, position_reg,
                                     is_active, phase_reg};
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            ret_reg           <= S_IDLE;
            phase_reg         <= PH_IDLE;
            position_reg      <= '0;
            level_reg         <= '0;
            lac_reg           <= '0;
            change_moment_reg <= '0;
            play_moment_reg   <= '0;
            fin_len_reg       <= '0;
            fout_len_reg      <= '0;
            m_tvalid_reg      <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            ret_reg           <= ret_next;
            phase_reg         <= phase_next;
            position_reg      <= position_next;
            level_reg         <= level_next;
            lac_reg           <= lac_next;
            change_moment_reg <= change_moment_next;
            play_moment_reg   <= play_moment_next;
            fin_len_reg       <= fin_len_next;
            fout_len_reg      <= fout_len_next;
            m_tvalid_reg      <= m_tvalid_next;
        end
    end

    // captured transaction and result payload
    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        fin_req_reg  <= fin_req_next;
        m_tdata_reg  <= m_tdata_next;
    end

    // register writes, always accepted; unknown index ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clip_duration_reg    <= 32'd65536;
            ticks_per_second_reg <= 32'd1638400;
            play_speed_reg       <= 16'd256;
            start_offset_reg     <= 32'd0;
            blend_weight_reg     <= ONE_Q15;
            loops_reg            <= 1'b1;
            holds_at_end_reg     <= 1'b0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_DURATION: clip_duration_reg    <= cfg_data;
                CFG_TPS:      ticks_per_second_reg <= cfg_data;
                CFG_SPEED:    play_speed_reg       <= cfg_data[15:0];
                CFG_OFFSET:   start_offset_reg     <= cfg_data;
                CFG_WEIGHT:   blend_weight_reg     <= cfg_data[15:0];
                CFG_LOOPS:    loops_reg            <= cfg_data[0];
                CFG_HOLD:     holds_at_end_reg     <= cfg_data[0];
                default:      ;
            endcase
        end
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign cfg_ready = 1'b1;

`ifndef NO_ASSERTIONS
    // an idle clip always has zero fade level
    a_idle_level: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_IDLE |-> level_reg == 16'd0)
        else $error("idle phase with nonzero level");

    // fade level never exceeds one
    a_level_max: assert property (@(posedge clk) disable iff (!rst_n)
        level_reg <= ONE_Q15)
        else $error("fade level above one");

    // no new transaction while the shared unit still works
    a_idle_unit: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !alu_st.busy)
        else $error("shared unit busy while accepting");

    // unit results arrive only while the sequencer waits for them
    a_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        alu_st.done |-> state_reg == S_WAIT)
        else $error("unit result outside wait state");
`endif

endmodule
